@@ sv/gbd_pkg.sv @@
// ----------------------------------------------------------------------------
// gbd_pkg: shared constants, types and tables
// Widths, angle constants and the arctangent table for the bearing/distance
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package gbd_pkg;

   // coordinate and field widths
   localparam int COORD_BITS = 16;
   localparam int FIELD_W    = 16;
   localparam int BRG_W      = 17;
   localparam int DIST_W     = 25;

   // difference and magnitude widths (|diff| <= 2^COORD_BITS - 1)
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int MAG_W      = COORD_BITS;
   localparam int SQ_W       = 2 * COORD_BITS;
   localparam int SUMSQ_W    = 2 * COORD_BITS + 1;

   // vectoring datapath
   localparam int FRAC_SHIFT = 30;
   localparam int XY_W       = COORD_BITS + 34;
   localparam int ANG_W      = 26;
   localparam int TURN_W     = 25;
   localparam int ITERS      = 23;
   localparam int RND_BITS   = 8;

   // square root datapath: radicand is sum of squares times 2^16
   localparam int RAD_SHIFT  = 16;
   localparam int SQ_STEPS   = COORD_BITS + 9;
   localparam int RAD_W      = 2 * SQ_STEPS;
   localparam int REM_W      = SQ_STEPS + 3;
   localparam int SAT_W      = (SQ_STEPS + 1 > DIST_W) ? SQ_STEPS + 1 : DIST_W;

   // pipeline depth: both datapaths run the same number of step stages
   localparam int PIPE_STEPS = (ITERS > SQ_STEPS) ? ITERS : SQ_STEPS;
   localparam int PIPE_LAT   = PIPE_STEPS + 5;

   // angle constants, accumulator counts 2^-16 degree
   localparam logic [ANG_W-1:0]  HALF_TURN_Z = ANG_W'(180 * 65536);
   localparam logic [TURN_W-1:0] FULL_TURN_Z = TURN_W'(360 * 65536);
   localparam logic [BRG_W:0]    BRG_WRAP    = (BRG_W + 1)'(360 * 256);
   localparam logic [TURN_W:0]   RND_HALF    = (TURN_W + 1)'(128);

   // bearings of the axis directions, 1/256 degree
   localparam logic [BRG_W-1:0] BRG_RIGHT = BRG_W'(0);
   localparam logic [BRG_W-1:0] BRG_UP    = BRG_W'(90 * 256);
   localparam logic [BRG_W-1:0] BRG_LEFT  = BRG_W'(180 * 256);
   localparam logic [BRG_W-1:0] BRG_DOWN  = BRG_W'(270 * 256);

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // control bundle traveling with each transaction
   typedef struct packed {
      logic             vld;
      logic             fix;
      logic [BRG_W-1:0] fix_brg;
   } gbd_ctl_type;

   // atan(2^-i) in 2^-16 degree, rounded
   function automatic logic [ANG_W-1:0] atan_lut(input int unsigned idx);
      logic [ANG_W-1:0] val;
      case (idx)
         0:       val = ANG_W'(2949120);
         1:       val = ANG_W'(1740967);
         2:       val = ANG_W'(919879);
         3:       val = ANG_W'(466945);
         4:       val = ANG_W'(234379);
         5:       val = ANG_W'(117304);
         6:       val = ANG_W'(58666);
         7:       val = ANG_W'(29335);
         8:       val = ANG_W'(14668);
         9:       val = ANG_W'(7334);
         10:      val = ANG_W'(3667);
         11:      val = ANG_W'(1833);
         12:      val = ANG_W'(917);
         13:      val = ANG_W'(458);
         14:      val = ANG_W'(229);
         15:      val = ANG_W'(115);
         16:      val = ANG_W'(57);
         17:      val = ANG_W'(29);
         18:      val = ANG_W'(14);
         19:      val = ANG_W'(7);
         20:      val = ANG_W'(4);
         21:      val = ANG_W'(2);
         22:      val = ANG_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

@@ sv/gbd_cordic.sv @@
// ----------------------------------------------------------------------------
// gbd_cordic: pipelined vectoring CORDIC
// ITERS rotation stages, then wrap to one turn and round to 1/256 degree.
// Axis directions bypass the iterations through the control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module gbd_cordic
   import gbd_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  gbd_ctl_type                  vec_ctl,
   input  wire logic signed [XY_W-1:0]  vec_x,
   input  wire logic signed [XY_W-1:0]  vec_y,
   input  wire logic signed [ANG_W-1:0] vec_z,
   output logic                         brg_vld,
   output logic [BRG_W-1:0]             brg
);

   gbd_ctl_type              ctl_ff [PIPE_STEPS];
   logic signed [XY_W-1:0]   x_ff   [PIPE_STEPS];
   logic signed [XY_W-1:0]   y_ff   [PIPE_STEPS];
   logic signed [ANG_W-1:0]  z_ff   [PIPE_STEPS];

   for (genvar k = 0; k < PIPE_STEPS; k++) begin : g_step
      gbd_ctl_type             ctl_p;
      logic signed [XY_W-1:0]  x_p, y_p, x_in, y_in;
      logic signed [ANG_W-1:0] z_p, z_in;

      if (k == 0) begin : g_first
         assign ctl_p = vec_ctl;
         assign x_p   = vec_x;
         assign y_p   = vec_y;
         assign z_p   = vec_z;
      end else begin : g_next
         assign ctl_p = ctl_ff[k-1];
         assign x_p   = x_ff[k-1];
         assign y_p   = y_ff[k-1];
         assign z_p   = z_ff[k-1];
      end

      if (k < ITERS) begin : g_rot
         always_comb begin
            if (y_p > 0) begin
               x_in = x_p + (y_p >>> k);
               y_in = y_p - (x_p >>> k);
               z_in = z_p + atan_lut(k);
            end else begin
               x_in = x_p - (y_p >>> k);
               y_in = y_p + (x_p >>> k);
               z_in = z_p - atan_lut(k);
            end
         end
      end else begin : g_pass
         assign x_in = x_p;
         assign y_in = y_p;
         assign z_in = z_p;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k].vld <= 1'b0;
         end else begin
            ctl_ff[k] <= ctl_p;
         end
         x_ff[k] <= x_in;
         y_ff[k] <= y_in;
         z_ff[k] <= z_in;
      end
   end

   // wrap into one turn; accumulator never goes past a full turn
   gbd_ctl_type       wrp_ctl_ff;
   logic [TURN_W-1:0] wrp_z_ff, wrp_z_in;

   always_comb begin
      if (z_ff[PIPE_STEPS-1] < 0) begin
         wrp_z_in = TURN_W'(z_ff[PIPE_STEPS-1]) + FULL_TURN_Z;
      end else begin
         wrp_z_in = TURN_W'(z_ff[PIPE_STEPS-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrp_ctl_ff.vld <= 1'b0;
      end else begin
         wrp_ctl_ff <= ctl_ff[PIPE_STEPS-1];
      end
      wrp_z_ff <= wrp_z_in;
   end

   // round to 1/256 degree, fold a full turn back to zero
   logic [TURN_W:0]  rnd_sum;
   logic [BRG_W:0]   rnd_brg;
   logic [BRG_W-1:0] brg_ff, brg_in;
   logic             vld_ff;

   always_comb begin
      rnd_sum = {1'b0, wrp_z_ff} + RND_HALF;
      rnd_brg = rnd_sum[TURN_W:RND_BITS];
      if (rnd_brg >= BRG_WRAP) begin
         rnd_brg = rnd_brg - BRG_WRAP;
      end
      if (wrp_ctl_ff.fix) begin
         brg_in = wrp_ctl_ff.fix_brg;
      end else begin
         brg_in = rnd_brg[BRG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= wrp_ctl_ff.vld;
      end
      brg_ff <= brg_in;
   end

   assign brg_vld = vld_ff;
   assign brg     = brg_ff;

endmodule

`default_nettype wire

@@ sv/gbd_isqrt.sv @@
// ----------------------------------------------------------------------------
// gbd_isqrt: pipelined digit-by-digit square root
// One result bit per stage, then round to nearest and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module gbd_isqrt
   import gbd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic [RAD_W-1:0]  rad,
   output logic      [DIST_W-1:0] distance
);

   logic [RAD_W-1:0]    rad_ff  [PIPE_STEPS];
   logic [REM_W-1:0]    rem_ff  [PIPE_STEPS];
   logic [SQ_STEPS-1:0] root_ff [PIPE_STEPS];

   for (genvar k = 0; k < PIPE_STEPS; k++) begin : g_step
      logic [RAD_W-1:0]    rad_p, rad_in;
      logic [REM_W-1:0]    rem_p, rem_in, rem_sh, trial;
      logic [SQ_STEPS-1:0] root_p, root_in;

      if (k == 0) begin : g_first
         assign rad_p  = rad;
         assign rem_p  = '0;
         assign root_p = '0;
      end else begin : g_next
         assign rad_p  = rad_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
      end

      if (k < SQ_STEPS) begin : g_digit
         always_comb begin
            rem_sh = {rem_p[REM_W-3:0], rad_p[RAD_W-1 -: 2]};
            trial  = {1'b0, root_p, 2'b01};
            rad_in = rad_p << 2;
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_p[SQ_STEPS-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_p[SQ_STEPS-2:0], 1'b0};
            end
         end
      end else begin : g_pass
         assign rem_sh  = '0;
         assign trial   = '0;
         assign rad_in  = rad_p;
         assign rem_in  = rem_p;
         assign root_in = root_p;
      end

      always_ff @(posedge clock) begin
         rad_ff[k]  <= rad_in;
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
      end
   end

   // round: remainder above root means the true root is past the half point
   logic [SQ_STEPS:0] rnd_ff, rnd_in;

   always_comb begin
      if (rem_ff[PIPE_STEPS-1] > REM_W'(root_ff[PIPE_STEPS-1])) begin
         rnd_in = {1'b0, root_ff[PIPE_STEPS-1]} + 1'b1;
      end else begin
         rnd_in = {1'b0, root_ff[PIPE_STEPS-1]};
      end
   end

   always_ff @(posedge clock) begin
      rnd_ff <= rnd_in;
   end

   // saturate to the output width
   logic [SAT_W-1:0]  sat_ext;
   logic [DIST_W-1:0] dist_ff, dist_in;

   always_comb begin
      sat_ext = SAT_W'(rnd_ff);
      if (sat_ext > SAT_W'(DIST_MAX)) begin
         dist_in = DIST_MAX;
      end else begin
         dist_in = sat_ext[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
   end

   assign distance = dist_ff;

endmodule

`default_nettype wire

@@ sv/grid_bearing_and_distance.sv @@
// ----------------------------------------------------------------------------
// grid_bearing_and_distance: bearing and distance between two grid points
// Pipelined CORDIC bearing and digit-serial-per-stage square root distance.
// ----------------------------------------------------------------------------
// Usage:
//  - Request: drive req_current_x/y and req_target_x/y and pulse start. A
//    transaction is taken on every rising edge with start high and busy low.
//    busy stays low: a new transaction may enter on every cycle.
//  - Response: rsp_valid is high for one cycle with rsp_bearing (1/256 deg,
//    counterclockwise from +x, 0..92159) and rsp_distance (1/256 units).
//    The receiver cannot stall; every response must be taken when shown.
//  - Pipeline: three front stages (differences; magnitudes, squares and
//    quadrant fold; sum of squares and CORDIC prescale), then 25 step
//    stages (23 CORDIC rotations and 25 root bits share the stage count),
//    then two stages of wrap/round and round/saturate.
//  - Throughput: one transaction per cycle, set by one step per stage.
//  - Reset: synchronous; clears all valid bits, drops work in flight. The
//    block is ready on the first cycle after reset.
//  - Equal points give bearing 0, distance 0; axis directions bypass the
//    rotations and return exact bearings.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_bearing_and_distance
   import gbd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [FIELD_W-1:0] req_current_x,
   input  wire logic [FIELD_W-1:0] req_current_y,
   input  wire logic [FIELD_W-1:0] req_target_x,
   input  wire logic [FIELD_W-1:0] req_target_y,
   output logic                    rsp_valid,
   output logic [BRG_W-1:0]        rsp_bearing,
   output logic [DIST_W-1:0]       rsp_distance
);

   // fully pipelined, never back-pressures
   assign busy = 1'b0;

   // ---- stage 1: differences, inputs read in their low COORD_BITS bits ----
   logic signed [COORD_BITS-1:0] cur_x, cur_y, tgt_x, tgt_y;
   logic                         vld1_ff;
   logic signed [DIFF_W-1:0]     dx1_ff, dx1_in, dy1_ff, dy1_in;

   assign cur_x  = req_current_x[COORD_BITS-1:0];
   assign cur_y  = req_current_y[COORD_BITS-1:0];
   assign tgt_x  = req_target_x[COORD_BITS-1:0];
   assign tgt_y  = req_target_y[COORD_BITS-1:0];
   assign dx1_in = DIFF_W'(tgt_x) - DIFF_W'(cur_x);
   assign dy1_in = DIFF_W'(tgt_y) - DIFF_W'(cur_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= start && !busy;
      end
      dx1_ff <= dx1_in;
      dy1_ff <= dy1_in;
   end

   // ---- stage 2: magnitudes and squares, axis bypass, fold left half ----
   logic [MAG_W-1:0]         mag_x, mag_y;
   logic                     dx_neg;
   gbd_ctl_type              ctl2_ff, ctl2_in;
   logic [SQ_W-1:0]          sqx2_ff, sqx2_in, sqy2_ff, sqy2_in;
   logic signed [DIFF_W-1:0] nx2_ff, nx2_in, ny2_ff, ny2_in;
   logic                     neg2_ff;

   always_comb begin
      dx_neg  = dx1_ff[DIFF_W-1];
      mag_x   = MAG_W'(dx_neg ? -dx1_ff : dx1_ff);
      mag_y   = MAG_W'(dy1_ff[DIFF_W-1] ? -dy1_ff : dy1_ff);
      sqx2_in = mag_x * mag_x;
      sqy2_in = mag_y * mag_y;
      // rotate the left half plane by a half turn so x starts positive
      nx2_in  = dx_neg ? -dx1_ff : dx1_ff;
      ny2_in  = dx_neg ? -dy1_ff : dy1_ff;

      ctl2_in.vld = vld1_ff;
      if (dy1_ff == '0) begin
         // includes the equal-points case
         ctl2_in.fix     = 1'b1;
         ctl2_in.fix_brg = dx_neg ? BRG_LEFT : BRG_RIGHT;
      end else if (dx1_ff == '0) begin
         ctl2_in.fix     = 1'b1;
         ctl2_in.fix_brg = dy1_ff[DIFF_W-1] ? BRG_DOWN : BRG_UP;
      end else begin
         ctl2_in.fix     = 1'b0;
         ctl2_in.fix_brg = BRG_RIGHT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff.vld <= 1'b0;
      end else begin
         ctl2_ff <= ctl2_in;
      end
      sqx2_ff <= sqx2_in;
      sqy2_ff <= sqy2_in;
      nx2_ff  <= nx2_in;
      ny2_ff  <= ny2_in;
      neg2_ff <= dx_neg;
   end

   // ---- stage 3: radicand and CORDIC prescale ----
   logic [SUMSQ_W-1:0]      sumsq;
   gbd_ctl_type             ctl3_ff;
   logic [RAD_W-1:0]        rad3_ff, rad3_in;
   logic signed [XY_W-1:0]  x3_ff, x3_in, y3_ff, y3_in;
   logic signed [ANG_W-1:0] z3_ff, z3_in;

   always_comb begin
      sumsq   = SUMSQ_W'(sqx2_ff) + SUMSQ_W'(sqy2_ff);
      rad3_in = RAD_W'(sumsq) << RAD_SHIFT;
      x3_in   = XY_W'(nx2_ff) <<< FRAC_SHIFT;
      y3_in   = XY_W'(ny2_ff) <<< FRAC_SHIFT;
      z3_in   = neg2_ff ? HALF_TURN_Z : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff.vld <= 1'b0;
      end else begin
         ctl3_ff <= ctl2_ff;
      end
      rad3_ff <= rad3_in;
      x3_ff   <= x3_in;
      y3_ff   <= y3_in;
      z3_ff   <= z3_in;
   end

   // ---- step stages and output stages; equal depth in both units ----
   gbd_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .vec_ctl (ctl3_ff),
      .vec_x   (x3_ff),
      .vec_y   (y3_ff),
      .vec_z   (z3_ff),
      .brg_vld (rsp_valid),
      .brg     (rsp_bearing)
   );

   gbd_isqrt u_isqrt (
      .clock    (clock),
      .rad      (rad3_ff),
      .distance (rsp_distance)
   );

   // ---- checks ----
   a_lat_fwd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LAT rsp_valid)
      else $error("transaction did not produce a response at fixed latency");

   a_lat_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LAT))
      else $error("response without a matching transaction");

   a_brg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_bearing} < BRG_WRAP))
      else $error("bearing not wrapped to one turn");

   a_zero_dist: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_distance == '0) |-> (rsp_bearing == BRG_RIGHT))
      else $error("equal points with nonzero bearing");

endmodule

`default_nettype wire
